/* rtl/core/one_wire_bus_master_top_assert.svh */
// Assertion macros for the one-wire bus master.
// OWM_ASSERT_IMP: same-cycle implication. OWM_ASSERT_NXT: next-cycle implication.
`ifndef ONE_WIRE_BUS_MASTER_TOP_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define OWM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("one-wire master check failed");
`define OWM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("one-wire master check failed");
`else
`define OWM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OWM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/owm_pkg.sv */
`default_nettype none
package owm_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;

  // register indexes on the configuration port
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [2:0] REG_SHORT_LOW     = 3'd3;
  localparam logic [2:0] REG_SLOT          = 3'd4;
  localparam logic [2:0] REG_RECOVERY      = 3'd5;

  localparam logic [9:0] RESET_LOW_DEF     = 10'd480;
  localparam logic [9:0] PRESENCE_WAIT_DEF = 10'd80;
  localparam logic [9:0] RESET_TAIL_DEF    = 10'd400;
  localparam logic [3:0] SHORT_LOW_DEF     = 4'd1;
  localparam logic [7:0] SLOT_DEF          = 8'd50;
  localparam logic [3:0] RECOVERY_DEF      = 4'd0;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_RST_LOW  = 7'b0000010,
    PH_RST_WAIT = 7'b0000100,
    PH_RST_TAIL = 7'b0001000,
    PH_SLOT_LOW = 7'b0010000,
    PH_SLOT_REL = 7'b0100000,
    PH_RECOVER  = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [9:0] reset_low;
    logic [9:0] presence_wait;
    logic [9:0] reset_tail;
    logic [3:0] short_low;
    logic [7:0] slot;
    logic [3:0] recovery;
  } cfg_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] write_byte;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
  } res_t;

endpackage
`default_nettype wire

/* rtl/core/owm_in_if.sv */
`default_nettype none
interface owm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] write_byte;
  logic       line_level;

  modport source (output valid, output op, output write_byte, output line_level,
                  input ready);
  modport sink (input valid, input op, input write_byte, input line_level,
                output ready);
endinterface
`default_nettype wire

/* rtl/core/owm_out_if.sv */
`default_nettype none
interface owm_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] read_data;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output presence, output read_data, input ready);
  modport sink (input valid, input drive_low, input busy_res, input done_res,
                input presence, input read_data, output ready);
endinterface
`default_nettype wire

/* rtl/core/owm_cfg.sv */
`default_nettype none
module owm_cfg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [9:0]   cfg_data,
  output owm_pkg::cfg_t     cfg
);

  owm_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low     <= owm_pkg::RESET_LOW_DEF;
      cfg_r.presence_wait <= owm_pkg::PRESENCE_WAIT_DEF;
      cfg_r.reset_tail    <= owm_pkg::RESET_TAIL_DEF;
      cfg_r.short_low     <= owm_pkg::SHORT_LOW_DEF;
      cfg_r.slot          <= owm_pkg::SLOT_DEF;
      cfg_r.recovery      <= owm_pkg::RECOVERY_DEF;
    end else if (cfg_we) begin
      case (cfg_index)
        owm_pkg::REG_RESET_LOW:     cfg_r.reset_low     <= cfg_data;
        owm_pkg::REG_PRESENCE_WAIT: cfg_r.presence_wait <= cfg_data;
        owm_pkg::REG_RESET_TAIL:    cfg_r.reset_tail    <= cfg_data;
        owm_pkg::REG_SHORT_LOW:     cfg_r.short_low     <= cfg_data[3:0];
        owm_pkg::REG_SLOT:          cfg_r.slot          <= cfg_data[7:0];
        owm_pkg::REG_RECOVERY:      cfg_r.recovery      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

/* rtl/core/owm_engine.sv */
`default_nettype none
module owm_engine #(
  parameter int unsigned BITS_PER_BYTE = owm_pkg::BITS_PER_BYTE
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step_en,
  input  wire owm_pkg::item_t item,
  input  wire owm_pkg::cfg_t  cfg,
  output owm_pkg::res_t      res
);

  owm_pkg::phase_t ph_r, ph_nxt;
  owm_pkg::op_t    cmd_r, cmd_nxt;
  logic [9:0]      tc_r, tc_nxt;
  logic [2:0]      bi_r, bi_nxt;
  logic [7:0]      sb_r, sb_nxt;
  logic            pres_r, pres_nxt;
  logic [7:0]      rb_r, rb_nxt;

  logic [9:0] len;
  logic       wr_zero;
  logic       last_tick;
  logic       end_slot;
  logic       fin;
  logic       done;

  function automatic logic [9:0] at_least_one(input logic [9:0] v);
    at_least_one = (v == 10'd0) ? 10'd1 : v;
  endfunction

  always_comb begin
    ph_nxt   = ph_r;
    cmd_nxt  = cmd_r;
    tc_nxt   = tc_r;
    bi_nxt   = bi_r;
    sb_nxt   = sb_r;
    pres_nxt = pres_r;
    rb_nxt   = rb_r;
    end_slot = 1'b0;
    fin      = 1'b0;
    done     = 1'b0;

    // a command is only taken while idle; it starts on this same tick
    if (ph_r == owm_pkg::PH_IDLE && item.op != owm_pkg::OP_TICK) begin
      cmd_nxt = item.op;
      tc_nxt  = 10'd0;
      bi_nxt  = 3'd0;
      if (item.op == owm_pkg::OP_RESET) begin
        ph_nxt = owm_pkg::PH_RST_LOW;
      end else begin
        sb_nxt = (item.op == owm_pkg::OP_WRITE) ? item.write_byte : 8'd0;
        ph_nxt = owm_pkg::PH_SLOT_LOW;
      end
    end

    res.drive_low = (ph_nxt == owm_pkg::PH_RST_LOW) || (ph_nxt == owm_pkg::PH_SLOT_LOW);
    res.busy_res  = (ph_nxt != owm_pkg::PH_IDLE);

    wr_zero = (cmd_nxt == owm_pkg::OP_WRITE) && !sb_nxt[bi_nxt];

    case (ph_nxt)
      owm_pkg::PH_RST_LOW:  len = at_least_one(cfg.reset_low);
      owm_pkg::PH_RST_WAIT: len = at_least_one(cfg.presence_wait);
      owm_pkg::PH_RST_TAIL: len = at_least_one(cfg.reset_tail);
      owm_pkg::PH_SLOT_LOW: len = wr_zero ? at_least_one({2'b00, cfg.slot})
                                          : at_least_one({6'd0, cfg.short_low});
      owm_pkg::PH_SLOT_REL: len = at_least_one({2'b00, cfg.slot});
      owm_pkg::PH_RECOVER:  len = at_least_one({6'd0, cfg.recovery});
      default:              len = 10'd1;
    endcase

    last_tick = ({1'b0, tc_nxt} + 11'd1) >= {1'b0, len};

    if (ph_nxt != owm_pkg::PH_IDLE) begin
      if (ph_nxt == owm_pkg::PH_RST_TAIL && tc_nxt == 10'd0) begin
        pres_nxt = !item.line_level;
      end
      // read slot: sample on the first released tick
      if (ph_nxt == owm_pkg::PH_SLOT_REL && tc_nxt == 10'd0 &&
          cmd_nxt == owm_pkg::OP_READ) begin
        sb_nxt[bi_nxt] = sb_nxt[bi_nxt] | item.line_level;
      end
      if (!last_tick) begin
        tc_nxt = tc_nxt + 10'd1;
      end else begin
        tc_nxt = 10'd0;
        case (ph_nxt)
          owm_pkg::PH_RST_LOW:  ph_nxt = owm_pkg::PH_RST_WAIT;
          owm_pkg::PH_RST_WAIT: ph_nxt = owm_pkg::PH_RST_TAIL;
          owm_pkg::PH_RST_TAIL: fin = 1'b1;
          owm_pkg::PH_SLOT_LOW: begin
            if (wr_zero) end_slot = 1'b1;
            else ph_nxt = owm_pkg::PH_SLOT_REL;
          end
          owm_pkg::PH_SLOT_REL: end_slot = 1'b1;
          owm_pkg::PH_RECOVER: begin
            bi_nxt = bi_nxt + 3'd1;
            ph_nxt = owm_pkg::PH_SLOT_LOW;
          end
          default: ph_nxt = owm_pkg::PH_IDLE;
        endcase
      end
    end

    if (end_slot) begin
      if (({1'b0, bi_nxt} + 4'd1) >= 4'(BITS_PER_BYTE)) begin
        fin = 1'b1;
      end else if (cfg.recovery != 4'd0) begin
        ph_nxt = owm_pkg::PH_RECOVER;
      end else begin
        bi_nxt = bi_nxt + 3'd1;
        ph_nxt = owm_pkg::PH_SLOT_LOW;
      end
    end

    if (fin) begin
      if (cmd_nxt == owm_pkg::OP_READ) rb_nxt = sb_nxt;
      ph_nxt = owm_pkg::PH_IDLE;
      done   = 1'b1;
    end

    res.done_res  = done;
    res.presence  = pres_nxt;
    res.read_data = rb_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= owm_pkg::PH_IDLE;
      cmd_r  <= owm_pkg::OP_TICK;
      tc_r   <= 10'd0;
      bi_r   <= 3'd0;
      sb_r   <= 8'd0;
      pres_r <= 1'b0;
      rb_r   <= 8'd0;
    end else if (step_en) begin
      ph_r   <= ph_nxt;
      cmd_r  <= cmd_nxt;
      tc_r   <= tc_nxt;
      bi_r   <= bi_nxt;
      sb_r   <= sb_nxt;
      pres_r <= pres_nxt;
      rb_r   <= rb_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/one_wire_bus_master_top.sv */
// Channel  Direction  Payload
// in_ch    sink       op[1:0], write_byte[7:0], line_level
// out_ch   source     drive_low, busy_res, done_res, presence, read_data[7:0]
// cfg_*    write      cfg_index[2:0], cfg_data[9:0]
//
// One tick item is processed per clock unless the output stalls; each transfer gives
// exactly one result. An item passes the input register, then the phase engine into
// the result register. A stalled output holds the result register; the input register
// keeps taking one more item until it is full. Reset is synchronous, active low.
`default_nettype none
`include "one_wire_bus_master_top_assert.svh"
module one_wire_bus_master_top #(
  parameter int unsigned BITS_PER_BYTE = owm_pkg::BITS_PER_BYTE
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  owm_in_if.sink          in_ch,
  owm_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [9:0] cfg_data
);

  logic           s1_v_r, s1_v_nxt;
  owm_pkg::item_t s1_item_r;
  logic           out_v_r, out_v_nxt;
  owm_pkg::res_t  out_res_r;
  owm_pkg::res_t  step_res;
  owm_pkg::cfg_t  cfg;
  logic           in_xfer;
  logic           step;

  assign step    = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !s1_v_r || step;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_xfer) s1_v_nxt = 1'b1;
    else if (step) s1_v_nxt = 1'b0;

    out_v_nxt = out_v_r;
    if (step) out_v_nxt = 1'b1;
    else if (out_ch.ready) out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.op         <= owm_pkg::op_t'(in_ch.op);
      s1_item_r.write_byte <= in_ch.write_byte;
      s1_item_r.line_level <= in_ch.line_level;
    end
    if (step) out_res_r <= step_res;
  end

  owm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  owm_engine #(
    .BITS_PER_BYTE (BITS_PER_BYTE)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step),
    .item    (s1_item_r),
    .cfg     (cfg),
    .res     (step_res)
  );

  assign out_ch.valid     = out_v_r;
  assign out_ch.drive_low = out_res_r.drive_low;
  assign out_ch.busy_res  = out_res_r.busy_res;
  assign out_ch.done_res  = out_res_r.done_res;
  assign out_ch.presence  = out_res_r.presence;
  assign out_ch.read_data = out_res_r.read_data;

  `OWM_ASSERT_IMP(a_done_busy, clk, rst_n, out_v_r && out_res_r.done_res, out_res_r.busy_res)
  `OWM_ASSERT_IMP(a_idle_released, clk, rst_n, out_v_r && !out_res_r.busy_res,
                  !out_res_r.drive_low)
  `OWM_ASSERT_IMP(a_stall_full, clk, rst_n, !in_ch.ready, s1_v_r && out_v_r)
  `OWM_ASSERT_NXT(a_step_fills, clk, rst_n, step, out_v_r)

endmodule
`default_nettype wire
